// ===== sv/ctws_pkg.sv =====
// ---------------------------------------------------------------------------
// ctws_pkg
// Shared types, sizes and codes for the cooperative task wait scheduler.
// ---------------------------------------------------------------------------
package ctws_pkg;

  // table sizes
  localparam int TASK_SLOTS  = 16;
  localparam int SEM_SLOTS   = 32;
  localparam int QUEUE_COUNT = 8;

  localparam int TIDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int NID_W  = $clog2(TASK_SLOTS + 1);
  localparam int SEM_AW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;

  // first semaphore index whose count is consumed on wake
  localparam int SEM_CONSUME_BASE = 2 * QUEUE_COUNT;

  // request codes
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_NEXT   = 3'd1,
    REQ_START  = 3'd2,
    REQ_SET    = 3'd3,
    REQ_WAIT   = 3'd4,
    REQ_WSEM   = 3'd5,
    REQ_SIGNAL = 3'd6,
    REQ_PRESET = 3'd7
  } req_t;

  // task conditions
  localparam logic [2:0] COND_IDLE      = 3'd0;
  localparam logic [2:0] COND_READY     = 3'd1;
  localparam logic [2:0] COND_WAIT_TMO  = 3'd2;
  localparam logic [2:0] COND_WAIT_SEM  = 3'd4;
  localparam logic [2:0] COND_WAIT_BOTH = 3'd6;

  // task events
  localparam logic [1:0] EV_RESET   = 2'd0;
  localparam logic [1:0] EV_SIGNAL  = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  localparam logic [7:0] SEM_MAX = 8'hFF;

  // one task table entry
  typedef struct packed {
    logic [2:0]  cond;
    logic [7:0]  fsm;
    logic [1:0]  ev;
    logic [4:0]  wsem;
    logic [15:0] timer;
  } task_rec_t;

  // controller state
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_TASK = 2'd1,
    S_SEM  = 2'd2,
    S_EXEC = 2'd3
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_task;
    logic rd_sem;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== sv/ctws_ctrl.sv =====
// ---------------------------------------------------------------------------
// ctws_ctrl
// Request sequencer: capture, task table read, semaphore read, commit, and
// the result valid flag.
// ---------------------------------------------------------------------------
module ctws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ctws_pkg::ctrl_cmd_t cmd
);

  ctws_pkg::state_t state, state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctws_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      ctws_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ctws_pkg::S_TASK;
        end
      end
      ctws_pkg::S_TASK: begin
        cmd.rd_task = 1'b1;
        state_next  = ctws_pkg::S_SEM;
      end
      ctws_pkg::S_SEM: begin
        cmd.rd_sem = 1'b1;
        state_next = ctws_pkg::S_EXEC;
      end
      ctws_pkg::S_EXEC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ctws_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ctws_pkg::S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // one request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a commit always raises the result
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without result valid");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.commit)
    else $error("pending result overwritten");

  // commands are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.rd_task, cmd.rd_sem, cmd.commit}))
    else $error("more than one command at once");

endmodule

// ===== sv/ctws_dp.sv =====
// ---------------------------------------------------------------------------
// ctws_dp
// Task table and semaphore pool with the evaluation and kernel call logic,
// cursor, task id allocator and result registers.
// ---------------------------------------------------------------------------
module ctws_dp (
  input  logic                clk,
  input  logic                rst,
  input  ctws_pkg::ctrl_cmd_t cmd,
  input  logic [2:0]          req_type,
  input  logic [4:0]          sem_index,
  input  logic [15:0]         timeout_ticks,
  input  logic [7:0]          state_value,
  input  logic [7:0]          preset_count,
  output logic [3:0]          task_index,
  output logic                dispatch,
  output logic [7:0]          task_state,
  output logic [1:0]          task_event,
  output logic                round_done,
  output logic                granted,
  output logic                error
);

  // control state
  logic [ctws_pkg::TIDX_W-1:0] cursor, cursor_next;
  logic [ctws_pkg::NID_W-1:0]  next_id, next_id_next;

  // captured request
  ctws_pkg::req_t              req;
  logic [4:0]                  req_sem;
  logic [15:0]                 req_tmo;
  logic [7:0]                  req_nst;
  logic [7:0]                  req_pre;
  logic [ctws_pkg::TIDX_W-1:0] addr_a, addr_a_next;
  logic [ctws_pkg::TIDX_W-1:0] addr_b;

  // task table and semaphore pool
  ctws_pkg::task_rec_t         task_mem [ctws_pkg::TASK_SLOTS];
  logic [ctws_pkg::TASK_SLOTS-1:0] task_vld;
  logic [7:0]                  sem_mem [ctws_pkg::SEM_SLOTS];
  logic [ctws_pkg::SEM_SLOTS-1:0]  sem_vld;

  // read data
  ctws_pkg::task_rec_t         rec_a, rec_b;
  logic [ctws_pkg::SEM_AW-1:0] sem_addr, sem_raddr;
  logic [7:0]                  sem_rd;

  // status
  logic cur_last, a_last, next_full, sem_ok, is_eval;

  // evaluation results
  ctws_pkg::task_rec_t ev_rec;
  logic                ev_semdec;

  // commit write data and result
  ctws_pkg::task_rec_t task_wd;
  logic                task_we, sem_we;
  logic [7:0]          sem_wd;
  logic [3:0]          o_idx;
  logic                o_disp, o_done, o_gr, o_err;
  logic [7:0]          o_state;
  logic [1:0]          o_ev;

  assign cur_last  = (32'(cursor) + 32'd1) >= ctws_pkg::TASK_SLOTS;
  assign a_last    = (32'(addr_a) + 32'd1) >= ctws_pkg::TASK_SLOTS;
  assign next_full = 32'(next_id) >= ctws_pkg::TASK_SLOTS;
  assign sem_ok    = 32'(req_sem) < ctws_pkg::SEM_SLOTS;
  assign is_eval   = (req == ctws_pkg::REQ_TICK) || (req == ctws_pkg::REQ_NEXT);

  // target entry for the incoming request
  always_comb begin
    case (ctws_pkg::req_t'(req_type))
      ctws_pkg::REQ_TICK:  addr_a_next = '0;
      ctws_pkg::REQ_NEXT:  addr_a_next = cur_last ? cursor : cursor + 1'b1;
      ctws_pkg::REQ_START: addr_a_next = ctws_pkg::TIDX_W'(next_id);
      default:             addr_a_next = cursor;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req     <= ctws_pkg::req_t'(req_type);
      req_sem <= sem_index;
      req_tmo <= timeout_ticks;
      req_nst <= state_value;
      req_pre <= preset_count;
      addr_a  <= addr_a_next;
      addr_b  <= addr_a_next + 1'b1;
    end
  end

  // task table read, unwritten entries read as reset value
  always_ff @(posedge clk) begin
    if (cmd.rd_task) begin
      rec_a <= task_vld[addr_a] ? task_mem[addr_a] : '0;
      rec_b <= task_vld[addr_b] ? task_mem[addr_b] : '0;
    end
  end

  // semaphore address: awaited one for evaluation, requested one otherwise
  assign sem_raddr = is_eval ? ctws_pkg::SEM_AW'(rec_a.wsem)
                             : ctws_pkg::SEM_AW'(req_sem);

  always_ff @(posedge clk) begin
    if (cmd.rd_sem) begin
      sem_addr <= sem_raddr;
      sem_rd   <= sem_vld[sem_raddr] ? sem_mem[sem_raddr] : '0;
    end
  end

  // task evaluation: semaphore wake, then timer countdown
  always_comb begin
    ev_rec    = rec_a;
    ev_semdec = 1'b0;
    if (ev_rec.cond[2]) begin
      if ((32'(rec_a.wsem) < ctws_pkg::SEM_SLOTS) && (sem_rd != 8'd0)) begin
        ev_semdec   = 32'(rec_a.wsem) >= ctws_pkg::SEM_CONSUME_BASE;
        ev_rec.ev   = ctws_pkg::EV_SIGNAL;
        ev_rec.cond = ctws_pkg::COND_READY;
      end
    end
    if (ev_rec.cond[1] && (ev_rec.timer != 16'd0)) begin
      ev_rec.timer = ev_rec.timer - 16'd1;
      if (ev_rec.timer == 16'd0) begin
        ev_rec.ev   = ctws_pkg::EV_TIMEOUT;
        ev_rec.cond = ctws_pkg::COND_READY;
      end
    end
  end

  // request execution
  always_comb begin
    task_wd      = rec_a;
    task_we      = 1'b0;
    sem_we       = 1'b0;
    sem_wd       = sem_rd;
    cursor_next  = cursor;
    next_id_next = next_id;
    o_idx        = 4'(cursor);
    o_disp       = 1'b0;
    o_state      = '0;
    o_ev         = '0;
    o_done       = 1'b0;
    o_gr         = 1'b0;
    o_err        = 1'b0;
    case (req)
      ctws_pkg::REQ_TICK, ctws_pkg::REQ_NEXT: begin
        if ((req == ctws_pkg::REQ_NEXT) && cur_last) begin
          o_done = 1'b1;
        end else begin
          cursor_next = addr_a;
          task_wd     = ev_rec;
          task_we     = 1'b1;
          sem_we      = ev_semdec;
          sem_wd      = sem_rd - 8'd1;
          o_idx       = 4'(addr_a);
          o_disp      = ev_rec.cond == ctws_pkg::COND_READY;
          o_state     = rec_a.fsm;
          o_ev        = ev_rec.ev;
          o_done      = a_last || (rec_b.cond == ctws_pkg::COND_IDLE);
        end
      end
      ctws_pkg::REQ_START: begin
        if (next_full) begin
          o_idx = '0;
          o_err = 1'b1;
        end else begin
          task_wd.cond  = ctws_pkg::COND_READY;
          task_wd.fsm   = '0;
          task_wd.ev    = ctws_pkg::EV_RESET;
          task_wd.timer = '0;
          task_we       = 1'b1;
          next_id_next  = next_id + 1'b1;
          o_idx         = 4'(addr_a);
        end
      end
      ctws_pkg::REQ_SET: begin
        task_wd.fsm = req_nst;
        task_we     = 1'b1;
      end
      ctws_pkg::REQ_WAIT: begin
        task_wd.timer = req_tmo;
        task_wd.cond  = ctws_pkg::COND_WAIT_TMO;
        task_we       = 1'b1;
      end
      ctws_pkg::REQ_WSEM: begin
        if (!sem_ok) begin
          o_err = 1'b1;
        end else if (sem_rd != 8'd0) begin
          sem_we       = 1'b1;
          sem_wd       = sem_rd - 8'd1;
          task_wd.cond = ctws_pkg::COND_READY;
          task_we      = 1'b1;
          o_gr         = 1'b1;
        end else begin
          task_wd.wsem = req_sem;
          task_wd.cond = ctws_pkg::COND_WAIT_SEM;
          if (req_tmo != 16'd0) begin
            task_wd.timer = req_tmo;
            task_wd.cond  = ctws_pkg::COND_WAIT_BOTH;
          end
          task_we = 1'b1;
        end
      end
      ctws_pkg::REQ_SIGNAL: begin
        if (!sem_ok) begin
          o_err = 1'b1;
        end else begin
          sem_we = sem_rd != ctws_pkg::SEM_MAX;
          sem_wd = sem_rd + 8'd1;
        end
      end
      ctws_pkg::REQ_PRESET: begin
        if (!sem_ok) begin
          o_err = 1'b1;
        end else begin
          sem_we = 1'b1;
          sem_wd = req_pre;
        end
      end
      default: begin
        o_err = 1'b0;
      end
    endcase
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.commit && task_we) begin
      task_mem[addr_a] <= task_wd;
    end
    if (cmd.commit && sem_we) begin
      sem_mem[sem_addr] <= sem_wd;
    end
  end

  // control state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      next_id  <= '0;
      task_vld <= '0;
      sem_vld  <= '0;
    end else if (cmd.commit) begin
      cursor  <= cursor_next;
      next_id <= next_id_next;
      if (task_we) begin
        task_vld[addr_a] <= 1'b1;
      end
      if (sem_we) begin
        sem_vld[sem_addr] <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      task_index <= o_idx;
      dispatch   <= o_disp;
      task_state <= o_state;
      task_event <= o_ev;
      round_done <= o_done;
      granted    <= o_gr;
      error      <= o_err;
    end
  end

  // cursor stays inside the table
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) < ctws_pkg::TASK_SLOTS)
    else $error("cursor beyond table");

  // task id allocator saturates at the table size
  a_nid_range: assert property (@(posedge clk) disable iff (rst)
    32'(next_id) <= ctws_pkg::TASK_SLOTS)
    else $error("task id allocator overflow");

  // signal never wraps a full count
  a_sem_sat: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (req == ctws_pkg::REQ_SIGNAL) && (sem_rd == ctws_pkg::SEM_MAX))
      |-> !sem_we)
    else $error("semaphore count wrapped");

endmodule

// ===== sv/cooperative_task_wait_scheduler.sv =====
// ---------------------------------------------------------------------------
// cooperative_task_wait_scheduler
// Cooperative scheduler kernel: task table, semaphore pool, round cursor.
// ---------------------------------------------------------------------------
// Sequence: after the capture edge, the task table read, semaphore read and
//   commit states follow in turn; commit waits while a result is pending.
// Issue: a new request is taken only after the current one commits, as the
//   dependent task read then semaphore read use the registered table ports.
// Reset: synchronous; clears cursor, task id allocator and all table entries
//   (entries read as zero until written), no clearing pass.
module cooperative_task_wait_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [4:0]  sem_index,
  input  logic [15:0] timeout_ticks,
  input  logic [7:0]  state_value,
  input  logic [7:0]  preset_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  task_index,
  output logic        dispatch,
  output logic [7:0]  task_state,
  output logic [1:0]  task_event,
  output logic        round_done,
  output logic        granted,
  output logic        error
);

  ctws_pkg::ctrl_cmd_t cmd;

  // sequencer
  ctws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // tables and request logic
  ctws_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .sem_index     (sem_index),
    .timeout_ticks (timeout_ticks),
    .state_value   (state_value),
    .preset_count  (preset_count),
    .task_index    (task_index),
    .dispatch      (dispatch),
    .task_state    (task_state),
    .task_event    (task_event),
    .round_done    (round_done),
    .granted       (granted),
    .error         (error)
  );

endmodule
